@@ rtl/scfe_pkg.sv @@
package scfe_pkg;

    // command codes on the op field
    typedef enum logic [2:0] {
        OP_SET_SPEED = 3'd0,
        OP_MOVE      = 3'd1,
        OP_ENABLE    = 3'd2,
        OP_READ_POS  = 3'd3,
        OP_READ_ENC  = 3'd4
    } op_t;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 4;
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DEVICE_ADDRESS = 4'd0,
        CFG_CLOSING_BYTE   = 4'd1
    } cfg_index_t;

    // register reset values
    localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'h01;
    localparam logic [7:0] CLOSING_BYTE_RESET   = 8'h6B;

    // driver opcodes
    localparam logic [7:0] OPC_SPEED    = 8'hF6;
    localparam logic [7:0] OPC_MOVE     = 8'hFD;
    localparam logic [7:0] OPC_ENABLE   = 8'hF3;
    localparam logic [7:0] OPC_READ_POS = 8'h36;
    localparam logic [7:0] OPC_READ_ENC = 8'h30;

    // field widths
    localparam int unsigned SPEED_W = 13;
    localparam int unsigned PULSE_W = 24;
    localparam int unsigned COUNT_W = 4;   // up to nine bytes per request

    typedef logic [COUNT_W-1:0] count_t;

endpackage

@@ rtl/stepper_command_frame_encoder.sv @@
// Stepper command frame encoder.
// Input channel (s_*): one motor command per request. Result channel (m_*):
// one frame byte per request, with the serial link it belongs to, a flag on
// the closing byte of each frame and a flag on the final byte of the command.
// Configuration channel (cfg_*): writes the driver address (index 0) and the
// closing byte (index 1); always ready, other indexes are ignored.
// Timing: a command is held in an input register and, while the receiver
// takes bytes, one byte per cycle is formed from it into the output
// register. A command yields 6, 9, 8 or 6 bytes (speed, move, enable, read);
// its first byte enters the output register once the command is held.
// The next command is accepted in the cycle its last byte enters the output
// register, so bytes leave back to back with no gap. A command producing no
// bytes (speed beyond limit, unused op) frees the input register unsent.
// Reset clears both channels and loads the address 0x01 and closing 0x6B.
// When the receiver stalls the output register holds its byte, the byte
// sequencer waits and s_ready falls once the held command still has bytes.
module stepper_command_frame_encoder #(
    parameter int unsigned MAX_SPEED = 1279
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // command input
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [2:0]                             s_op,
    input  logic signed [scfe_pkg::SPEED_W-1:0]    s_speed,
    input  logic [7:0]                             s_accel,
    input  logic [scfe_pkg::PULSE_W-1:0]           s_pulse_count,
    input  logic                                   s_wheel_select,
    input  logic                                   s_enable_flag,
    // frame byte output
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [7:0]                             m_tx_byte,
    output logic                                   m_channel,
    output logic                                   m_frame_end,
    output logic                                   m_last,
    // configuration writes
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [scfe_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [7:0]                             cfg_data
);

    // configuration registers
    logic [7:0] device_address_reg;
    logic [7:0] closing_byte_reg;

    // held command
    logic                              item_valid_reg;
    logic [2:0]                        item_op_reg;
    logic [scfe_pkg::SPEED_W-1:0]      item_speed_reg;
    logic [7:0]                        item_accel_reg;
    logic [scfe_pkg::PULSE_W-1:0]      item_pulse_reg;
    logic                              item_wheel_reg;
    logic                              item_flag_reg;
    scfe_pkg::count_t                  item_idx_reg;
    scfe_pkg::count_t                  item_idx_next;

    // output register
    logic       m_valid_reg;
    logic [7:0] m_tx_byte_reg;
    logic       m_channel_reg;
    logic       m_frame_end_reg;
    logic       m_last_reg;

    // decode
    logic                          neg;
    logic [scfe_pkg::SPEED_W-1:0]  mag;
    logic                          in_range;
    logic                          dir;
    logic                          ok;
    logic                          dual;
    logic [7:0]                    opcode;
    scfe_pkg::count_t              body_len;
    scfe_pkg::count_t              frame_len;
    scfe_pkg::count_t              total;
    logic                          second;
    scfe_pkg::count_t              pos;
    logic [7:0]                    body_byte;
    logic [7:0]                    byte_val;
    logic                          byte_chan;
    logic                          byte_fend;
    logic                          byte_last;
    logic                          out_free;
    logic                          advance;
    logic                          done;

    // speed magnitude and direction
    always_comb begin
        neg      = item_speed_reg[scfe_pkg::SPEED_W-1];
        mag      = neg ? (~item_speed_reg + {{(scfe_pkg::SPEED_W-1){1'b0}}, 1'b1})
                       : item_speed_reg;
        in_range = (mag <= scfe_pkg::SPEED_W'(MAX_SPEED));
        dir      = (neg == item_wheel_reg);
    end

    // command decode
    always_comb begin
        ok       = 1'b0;
        dual     = 1'b0;
        opcode   = scfe_pkg::OPC_SPEED;
        body_len = scfe_pkg::count_t'(1);
        case (scfe_pkg::op_t'(item_op_reg))
            scfe_pkg::OP_SET_SPEED: begin
                ok       = in_range;
                opcode   = scfe_pkg::OPC_SPEED;
                body_len = scfe_pkg::count_t'(4);
            end
            scfe_pkg::OP_MOVE: begin
                ok       = in_range;
                opcode   = scfe_pkg::OPC_MOVE;
                body_len = scfe_pkg::count_t'(7);
            end
            scfe_pkg::OP_ENABLE: begin
                ok       = 1'b1;
                dual     = 1'b1;
                opcode   = scfe_pkg::OPC_ENABLE;
                body_len = scfe_pkg::count_t'(2);
            end
            scfe_pkg::OP_READ_POS: begin
                ok       = 1'b1;
                dual     = 1'b1;
                opcode   = scfe_pkg::OPC_READ_POS;
            end
            scfe_pkg::OP_READ_ENC: begin
                ok       = 1'b1;
                dual     = 1'b1;
                opcode   = scfe_pkg::OPC_READ_ENC;
            end
            default: begin
                ok       = 1'b0;
            end
        endcase
        frame_len = body_len + scfe_pkg::count_t'(2);
        total     = dual ? (frame_len << 1) : frame_len;
    end

    // byte at the current index
    always_comb begin
        second = dual && (item_idx_reg >= frame_len);
        pos    = second ? (item_idx_reg - frame_len) : item_idx_reg;
        case (pos)
            scfe_pkg::count_t'(1): body_byte = opcode;
            scfe_pkg::count_t'(2): body_byte =
                (scfe_pkg::op_t'(item_op_reg) == scfe_pkg::OP_ENABLE)
                    ? {7'd0, item_flag_reg} : {3'd0, dir, mag[11:8]};
            scfe_pkg::count_t'(3): body_byte = mag[7:0];
            scfe_pkg::count_t'(4): body_byte = item_accel_reg;
            scfe_pkg::count_t'(5): body_byte = item_pulse_reg[23:16];
            scfe_pkg::count_t'(6): body_byte = item_pulse_reg[15:8];
            scfe_pkg::count_t'(7): body_byte = item_pulse_reg[7:0];
            default:               body_byte = 8'd0;
        endcase
        byte_fend = (pos == frame_len - scfe_pkg::count_t'(1));
        if (pos == '0) begin
            byte_val = device_address_reg;
        end else if (byte_fend) begin
            byte_val = closing_byte_reg;
        end else begin
            byte_val = body_byte;
        end
        byte_chan = dual ? second : item_wheel_reg;
        byte_last = (item_idx_reg == total - scfe_pkg::count_t'(1));
    end

    // handshake control
    assign out_free      = !m_valid_reg || m_ready;
    assign advance       = item_valid_reg && ok && out_free;
    assign done          = item_valid_reg && (!ok || (out_free && byte_last));
    assign s_ready       = !item_valid_reg || done;
    assign cfg_ready     = 1'b1;
    assign item_idx_next = item_idx_reg + scfe_pkg::count_t'(1);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_address_reg <= scfe_pkg::DEVICE_ADDRESS_RESET;
            closing_byte_reg   <= scfe_pkg::CLOSING_BYTE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (scfe_pkg::cfg_index_t'(cfg_index))
                scfe_pkg::CFG_DEVICE_ADDRESS: device_address_reg <= cfg_data;
                scfe_pkg::CFG_CLOSING_BYTE:   closing_byte_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // command register and byte index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            item_idx_reg   <= '0;
        end else if (s_valid && s_ready) begin
            item_valid_reg <= 1'b1;
            item_idx_reg   <= '0;
        end else if (done) begin
            item_valid_reg <= 1'b0;
        end else if (advance) begin
            item_idx_reg   <= item_idx_next;
        end
    end

    // command payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_op_reg    <= s_op;
            item_speed_reg <= s_speed;
            item_accel_reg <= s_accel;
            item_pulse_reg <= s_pulse_count;
            item_wheel_reg <= s_wheel_select;
            item_flag_reg  <= s_enable_flag;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_tx_byte_reg   <= byte_val;
            m_channel_reg   <= byte_chan;
            m_frame_end_reg <= byte_fend;
            m_last_reg      <= byte_last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_tx_byte   = m_tx_byte_reg;
    assign m_channel   = m_channel_reg;
    assign m_frame_end = m_frame_end_reg;
    assign m_last      = m_last_reg;

    // byte index stays inside the command's frame bytes
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid_reg && ok) |-> (item_idx_reg < total))
        else $error("byte index beyond command length");

    // the final byte of a command frees the input register in the same cycle
    a_last_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && byte_last) |-> s_ready)
        else $error("input not ready after final byte");

    // a closing byte carries the configured closing value
    a_close_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && byte_fend) |=> (m_frame_end && m_tx_byte == closing_byte_reg))
        else $error("closing byte mismatch");

endmodule

@@ sim/frame_byte_checker.sv @@
module frame_byte_checker #(
    parameter int unsigned MAX_SPEED = 1279
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // command channel
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic [2:0]                       s_op,
    input  logic [scfe_pkg::SPEED_W-1:0]     s_speed,
    input  logic [7:0]                       s_accel,
    input  logic [scfe_pkg::PULSE_W-1:0]     s_pulse_count,
    input  logic                             s_wheel_select,
    input  logic                             s_enable_flag,
    // frame byte channel
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic [7:0]                       m_tx_byte,
    input  logic                             m_channel,
    input  logic                             m_frame_end,
    input  logic                             m_last,
    // register writes
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [scfe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                       cfg_data,
    // status towards the top
    output int                               mismatches,
    output int                               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       channel;
        logic       frame_end;
        logic       last;
    } frame_byte_t;

    frame_byte_t expected_bytes[$];
    logic [7:0]  driver_address;
    logic [7:0]  closing_byte;
    int          error_total = 0;

    // one frame: address, body, closing byte
    task automatic push_frame(input logic [6:0][7:0] body, input int len, input logic link);
        frame_byte_t fb;
        fb = '{tx_byte: driver_address, channel: link, frame_end: 1'b0, last: 1'b0};
        expected_bytes.push_back(fb);
        for (int i = 0; i < len; i++) begin
            fb.tx_byte = body[i];
            expected_bytes.push_back(fb);
        end
        fb.tx_byte   = closing_byte;
        fb.frame_end = 1'b1;
        expected_bytes.push_back(fb);
    endtask

    // bytes that one command should produce
    task automatic encode_command(
        input logic [2:0]                   op,
        input logic [scfe_pkg::SPEED_W-1:0] speed,
        input logic [7:0]                   accel,
        input logic [scfe_pkg::PULSE_W-1:0] pulse,
        input logic                         wheel,
        input logic                         flag
    );
        logic [6:0][7:0]              body;
        int                           len;
        int                           first;
        logic                         neg;
        logic                         dir;
        logic [scfe_pkg::SPEED_W-1:0] mag;
        frame_byte_t                  tail;
        body  = '0;
        first = expected_bytes.size();
        case (op)
            scfe_pkg::OP_SET_SPEED, scfe_pkg::OP_MOVE: begin
                neg = speed[scfe_pkg::SPEED_W-1];
                mag = neg ? (scfe_pkg::SPEED_W'(0) - speed) : speed;
                dir = (neg == wheel);
                // over-limit speed gives no frame at all
                if (mag <= MAX_SPEED) begin
                    body[0] = (op == scfe_pkg::OP_SET_SPEED) ? scfe_pkg::OPC_SPEED
                                                             : scfe_pkg::OPC_MOVE;
                    body[1] = {3'b000, dir, mag[11:8]};
                    body[2] = mag[7:0];
                    body[3] = accel;
                    len     = 4;
                    if (op == scfe_pkg::OP_MOVE) begin
                        body[4] = pulse[23:16];
                        body[5] = pulse[15:8];
                        body[6] = pulse[7:0];
                        len     = 7;
                    end
                    push_frame(body, len, wheel);
                end
            end
            scfe_pkg::OP_ENABLE, scfe_pkg::OP_READ_POS, scfe_pkg::OP_READ_ENC: begin
                if (op == scfe_pkg::OP_ENABLE) begin
                    body[0] = scfe_pkg::OPC_ENABLE;
                    body[1] = {7'b0, flag};
                    len     = 2;
                end else begin
                    body[0] = (op == scfe_pkg::OP_READ_POS) ? scfe_pkg::OPC_READ_POS
                                                            : scfe_pkg::OPC_READ_ENC;
                    len     = 1;
                end
                // same frame to both drivers, up wheel first
                push_frame(body, len, 1'b0);
                push_frame(body, len, 1'b1);
            end
            default: begin
            end
        endcase
        if (expected_bytes.size() > first) begin
            tail      = expected_bytes.pop_back();
            tail.last = 1'b1;
            expected_bytes.push_back(tail);
        end
    endtask

    // field-by-field comparison against the oldest expectation
    task automatic check_byte();
        frame_byte_t want;
        if (expected_bytes.size() == 0) begin
            $display("%0t: frame byte %02h on link %0b with nothing expected",
                     $time, m_tx_byte, m_channel);
            error_total++;
        end else begin
            want = expected_bytes.pop_front();
            if (m_tx_byte !== want.tx_byte) begin
                $display("%0t: tx_byte expected %02h actual %02h",
                         $time, want.tx_byte, m_tx_byte);
                error_total++;
            end
            if (m_channel !== want.channel) begin
                $display("%0t: channel expected %0b actual %0b",
                         $time, want.channel, m_channel);
                error_total++;
            end
            if (m_frame_end !== want.frame_end) begin
                $display("%0t: frame_end expected %0b actual %0b",
                         $time, want.frame_end, m_frame_end);
                error_total++;
            end
            if (m_last !== want.last) begin
                $display("%0t: last expected %0b actual %0b",
                         $time, want.last, m_last);
                error_total++;
            end
        end
    endtask

    // watch all three channels
    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_bytes.delete();
            driver_address = scfe_pkg::DEVICE_ADDRESS_RESET;
            closing_byte   = scfe_pkg::CLOSING_BYTE_RESET;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == scfe_pkg::CFG_DEVICE_ADDRESS) begin
                    driver_address = cfg_data;
                end else if (cfg_index == scfe_pkg::CFG_CLOSING_BYTE) begin
                    closing_byte = cfg_data;
                end
            end
            if (s_valid && s_ready) begin
                encode_command(s_op, s_speed, s_accel, s_pulse_count,
                               s_wheel_select, s_enable_flag);
            end
            if (m_valid && m_ready) begin
                check_byte();
            end
        end
        mismatches  <= error_total;
        outstanding <= expected_bytes.size();
    end

endmodule

@@ sim/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SPEED_LIMIT = 1279;
    localparam int          STALL_LIMIT = 1000;
    localparam int          HOLD_CYCLES = 64;
    localparam int          SETTLE      = 12;
    // op values with no command behind them
    localparam logic [2:0]  OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0]  OP_SPARE_LAST  = 3'd7;

    logic                                aclk           = 1'b0;
    logic                                aresetn        = 1'b0;
    logic                                s_valid        = 1'b0;
    logic                                s_ready;
    logic [2:0]                          s_op           = '0;
    logic signed [scfe_pkg::SPEED_W-1:0] s_speed        = '0;
    logic [7:0]                          s_accel        = '0;
    logic [scfe_pkg::PULSE_W-1:0]        s_pulse_count  = '0;
    logic                                s_wheel_select = 1'b0;
    logic                                s_enable_flag  = 1'b0;
    logic                                m_valid;
    logic                                m_ready        = 1'b0;
    logic [7:0]                          m_tx_byte;
    logic                                m_channel;
    logic                                m_frame_end;
    logic                                m_last;
    logic                                cfg_valid      = 1'b0;
    logic                                cfg_ready;
    logic [scfe_pkg::CFG_INDEX_W-1:0]    cfg_index      = '0;
    logic [7:0]                          cfg_data       = '0;

    int   mismatches;
    int   outstanding;
    int   stall_cycles   = 0;
    logic sender_idles   = 1'b1;
    logic receiver_quiet = 1'b0;
    logic hold_off_req   = 1'b0;

    stepper_command_frame_encoder #(
        .MAX_SPEED(SPEED_LIMIT)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_speed       (s_speed),
        .s_accel       (s_accel),
        .s_pulse_count (s_pulse_count),
        .s_wheel_select(s_wheel_select),
        .s_enable_flag (s_enable_flag),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_tx_byte     (m_tx_byte),
        .m_channel     (m_channel),
        .m_frame_end   (m_frame_end),
        .m_last        (m_last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    frame_byte_checker #(
        .MAX_SPEED(SPEED_LIMIT)
    ) checker_inst (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_speed       (s_speed),
        .s_accel       (s_accel),
        .s_pulse_count (s_pulse_count),
        .s_wheel_select(s_wheel_select),
        .s_enable_flag (s_enable_flag),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_tx_byte     (m_tx_byte),
        .m_channel     (m_channel),
        .m_frame_end   (m_frame_end),
        .m_last        (m_last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // watchdog on cycles with no request accepted anywhere
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // receiver: random back-pressure, quiet stretch, one long hold-off
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
            end else begin
                m_ready <= receiver_quiet || ($urandom_range(99) >= 10);
            end
        end
    end

    // offer one command and wait for its acceptance
    task automatic send_command(
        input logic [2:0]                          op,
        input logic signed [scfe_pkg::SPEED_W-1:0] speed,
        input logic [7:0]                          accel,
        input logic [scfe_pkg::PULSE_W-1:0]        pulse,
        input logic                                wheel,
        input logic                                flag
    );
        s_valid        <= 1'b1;
        s_op           <= op;
        s_speed        <= speed;
        s_accel        <= accel;
        s_pulse_count  <= pulse;
        s_wheel_select <= wheel;
        s_enable_flag  <= flag;
        do @(posedge aclk); while (!s_ready);
    endtask

    // mostly in-range commands, a few over-limit speeds and spare ops
    task automatic send_random_command();
        logic [2:0]                          op;
        logic signed [scfe_pkg::SPEED_W-1:0] speed;
        int                                  pick;
        pick = $urandom_range(99);
        if (pick < 5) begin
            op = 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
        end else begin
            op = 3'($urandom_range(scfe_pkg::OP_READ_ENC, scfe_pkg::OP_SET_SPEED));
        end
        pick = $urandom_range(99);
        if (pick < 8) begin
            speed = scfe_pkg::SPEED_W'($urandom);
        end else if (pick < 14) begin
            speed = pick[0] ? scfe_pkg::SPEED_W'(SPEED_LIMIT)
                            : -scfe_pkg::SPEED_W'(SPEED_LIMIT);
        end else begin
            speed = scfe_pkg::SPEED_W'(int'($urandom_range(2 * SPEED_LIMIT))
                                       - int'(SPEED_LIMIT));
        end
        send_command(op, speed, 8'($urandom), scfe_pkg::PULSE_W'($urandom),
                     1'($urandom), 1'($urandom));
        if (sender_idles && $urandom_range(99) < 10) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
    endtask

    // stop offering and let every expected byte come out
    task automatic wait_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // both registers, back to back on the write channel
    task automatic write_registers(input logic [7:0] address, input logic [7:0] closing);
        cfg_valid <= 1'b1;
        cfg_index <= scfe_pkg::CFG_DEVICE_ADDRESS;
        cfg_data  <= address;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= scfe_pkg::CFG_CLOSING_BYTE;
        cfg_data  <= closing;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // stimulus and verdict
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed commands with reset register values
        send_command(scfe_pkg::OP_SET_SPEED, 13'sd0, 8'h00, 24'h000000, 1'b0, 1'b0);
        send_command(scfe_pkg::OP_SET_SPEED, 13'sd0, 8'hFF, 24'hFFFFFF, 1'b1, 1'b1);
        send_command(scfe_pkg::OP_SET_SPEED, 13'sd1279, 8'hA5, 24'h000000, 1'b0, 1'b0);
        send_command(scfe_pkg::OP_SET_SPEED, -13'sd1279, 8'h5A, 24'h000000, 1'b0, 1'b0);
        send_command(scfe_pkg::OP_SET_SPEED, -13'sd1279, 8'h5A, 24'h000000, 1'b1, 1'b0);
        send_command(scfe_pkg::OP_SET_SPEED, 13'sd1280, 8'h11, 24'h000000, 1'b0, 1'b0);
        send_command(scfe_pkg::OP_SET_SPEED, -13'sd1280, 8'h11, 24'h000000, 1'b1, 1'b0);
        send_command(scfe_pkg::OP_SET_SPEED, -13'sd4096, 8'h22, 24'h000000, 1'b0, 1'b0);
        send_command(scfe_pkg::OP_SET_SPEED, 13'sd4095, 8'h33, 24'h000000, 1'b1, 1'b0);
        send_command(scfe_pkg::OP_MOVE, -13'sd1, 8'hFF, 24'hFFFFFF, 1'b1, 1'b1);
        send_command(scfe_pkg::OP_MOVE, 13'sd1, 8'h00, 24'h000000, 1'b0, 1'b0);
        send_command(scfe_pkg::OP_MOVE, 13'sd1279, 8'h81, 24'hA5A5A5, 1'b0, 1'b1);
        send_command(scfe_pkg::OP_MOVE, -13'sd1279, 8'h7E, 24'h5A5A5A, 1'b1, 1'b0);
        send_command(scfe_pkg::OP_MOVE, 13'sd1280, 8'h44, 24'h123456, 1'b1, 1'b0);
        send_command(scfe_pkg::OP_ENABLE, 13'sd0, 8'h00, 24'h000000, 1'b0, 1'b1);
        send_command(scfe_pkg::OP_ENABLE, -13'sd4096, 8'hFF, 24'hFFFFFF, 1'b1, 1'b0);
        send_command(scfe_pkg::OP_READ_POS, 13'sd0, 8'h00, 24'h000000, 1'b1, 1'b0);
        send_command(scfe_pkg::OP_READ_ENC, -13'sd4096, 8'hFF, 24'hFFFFFF, 1'b0, 1'b1);
        send_command(OP_SPARE_FIRST, 13'sd5, 8'h00, 24'h000000, 1'b0, 1'b0);
        send_command(OP_SPARE_FIRST + 3'd1, 13'sd5, 8'h00, 24'h000000, 1'b1, 1'b1);
        send_command(OP_SPARE_LAST, 13'sd5, 8'hFF, 24'hFFFFFF, 1'b0, 1'b1);
        send_command(scfe_pkg::OP_READ_POS, 13'sd100, 8'h00, 24'h000000, 1'b0, 1'b0);
        wait_until_drained();

        // low address, high closing byte, receiver holds off at the start
        write_registers(8'h00, 8'hFF);
        hold_off_req = 1'b1;
        repeat (70) send_random_command();
        wait_until_drained();

        // opposite extremes, no idling on either side
        write_registers(8'hFF, 8'h00);
        sender_idles   = 1'b0;
        receiver_quiet = 1'b1;
        repeat (60) send_random_command();
        sender_idles   = 1'b1;
        receiver_quiet = 1'b0;
        wait_until_drained();

        // random register values
        write_registers(8'($urandom), 8'($urandom));
        repeat (60) send_random_command();
        wait_until_drained();

        write_registers(8'($urandom), 8'($urandom));
        repeat (60) send_random_command();
        wait_until_drained();

        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
